FILE: rtl/pcn_pkg.sv
// ----------------------------------------------------------------------------
// pcn_pkg
// Shared types and constants for the clock / NRU page replacement engine.
// ----------------------------------------------------------------------------
package pcn_pkg;

	localparam int MaxFrames  = 64;
	localparam int FrameW     = 6;
	localparam int CountW     = 7;
	localparam int PageW      = 21;
	localparam int OffsetBits = 11;
	localparam int AddrW      = 32;
	localparam int StampW     = 32;
	localparam int TotalW     = 32;
	localparam int RefreshW   = 20;
	localparam int IntervalW  = 21;
	localparam int KindW      = 2;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 32;

	localparam logic [KindW-1:0] KIND_MODIFY = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_MODE     = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_FRAMES   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_INTERVAL = 2'd2;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [AddrW-1:0] address;
	} access_t;

	typedef struct packed {
		logic               hit;
		logic               evicted;
		logic [PageW-1:0]   victim_page;
		logic               write_back;
		logic [FrameW-1:0]  frame_index;
		logic [TotalW-1:0]  access_total;
		logic [TotalW-1:0]  fault_total;
		logic [TotalW-1:0]  disk_write_total;
	} result_t;

	typedef struct packed {
		logic [CfgIdxW-1:0]  index;
		logic [CfgDataW-1:0] data;
	} cfg_t;

endpackage

FILE: rtl/pcn_if.sv
// ----------------------------------------------------------------------------
// pcn_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface pcn_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/page_replacement_clock_nru.sv
// ----------------------------------------------------------------------------
// page_replacement_clock_nru
// Page replacement engine: frame lookup, fill, and clock or NRU eviction.
// ----------------------------------------------------------------------------
// channel | dir | payload
// acc     | in  | kind, address
// res     | out | hit, evicted, victim_page, write_back, frame_index, totals
// cfg     | in  | index (0 mode, 1 num_frames, 2 refresh_interval), data
//
// A refresh step, then a hit search over all 64 frames, each frame taking a
// registered frame store read and then a compare; a miss adds a free search
// over the active frames, then a clock sweep or an NRU scan over them, and
// then a commit step.
// Reset clears valid, ref and dirty bits and all counters at once.
// acc ready stays low from acceptance until the result register is taken.
// ----------------------------------------------------------------------------
module page_replacement_clock_nru (
	input logic clk,
	input logic arst_n,
	pcn_if.sink   acc,
	pcn_if.source res,
	pcn_if.sink   cfg
);
	import pcn_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_REF   = 6'b000010,
		ST_HIT   = 6'b000100,
		ST_FREE  = 6'b001000,
		ST_EVICT = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic                 mode_q;
	logic [CountW-1:0]    frames_q;
	logic [IntervalW-1:0] interval_q;

	logic [PageW-1:0]  page_mem [MaxFrames];
	logic [StampW-1:0] age_mem [MaxFrames];
	logic [MaxFrames-1:0] valid_q, ref_q, dirty_q;

	logic [PageW-1:0]  rd_page_q;
	logic [StampW-1:0] rd_age_q;
	logic [FrameW-1:0] rd_idx_q;

	logic [StampW-1:0]   stamp_q;
	logic [FrameW-1:0]   hand_q;
	logic [RefreshW-1:0] refresh_q;
	logic [TotalW-1:0]   acc_cnt_q, fault_cnt_q, wr_cnt_q;

	logic [KindW-1:0]  kind_q;
	logic [PageW-1:0]  page_q;
	logic [CountW-1:0] n_q;
	logic [CountW-1:0] idx_q;
	logic [CountW-1:0] step_q;
	logic [FrameW-1:0] best_q;
	logic [1:0]        best_cls_q;
	logic [StampW-1:0] best_old_q;
	logic              best_any_q;
	logic              res_valid_q;
	result_t           res_q;

	logic [FrameW-1:0]  idx;
	logic               rd_ok;
	logic [1:0]         cls;
	logic [StampW-1:0]  old;
	logic [RefreshW-1:0] refresh_nx;
	logic               writes;
	logic               better;
	logic [CountW-1:0]  n_eff;

	assign idx     = idx_q[FrameW-1:0];
	// read data belongs to the frame under the index
	assign rd_ok   = (rd_idx_q == idx);
	assign cls     = {ref_q[idx], dirty_q[idx]};
	assign old     = stamp_q - rd_age_q;
	assign better  = !best_any_q || (cls < best_cls_q) ||
		(cls == best_cls_q && old > best_old_q);
	assign writes  = kind_q[1];
	assign refresh_nx = refresh_q + 1'b1;
	assign n_eff = (frames_q == '0) ? CountW'(1) :
		(frames_q > CountW'(MaxFrames)) ? CountW'(MaxFrames) : frames_q;

	assign acc.ready = (state_q == ST_IDLE) && !res_valid_q;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.payload = res_q;

	// frame store payload, written at fill time, read through a register in the cycle after the index
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !res_q.hit) begin
			page_mem[res_q.frame_index] <= page_q;
			age_mem[res_q.frame_index]  <= stamp_q;
		end
		rd_page_q <= page_mem[idx];
		rd_age_q  <= age_mem[idx];
		rd_idx_q  <= idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			frames_q    <= CountW'(64);
			interval_q  <= IntervalW'(1000);
			valid_q     <= '0;
			ref_q       <= '0;
			dirty_q     <= '0;
			stamp_q     <= '0;
			hand_q      <= '0;
			refresh_q   <= '0;
			acc_cnt_q   <= '0;
			fault_cnt_q <= '0;
			wr_cnt_q    <= '0;
			res_valid_q <= 1'b0;
			kind_q      <= '0;
			page_q      <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			best_q      <= '0;
			best_cls_q  <= '0;
			best_old_q  <= '0;
			best_any_q  <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.payload.index)
					REG_MODE:     mode_q     <= cfg.payload.data[0];
					REG_FRAMES:   frames_q   <= cfg.payload.data[CountW-1:0];
					REG_INTERVAL: interval_q <= cfg.payload.data[IntervalW-1:0];
					default: ;
				endcase
			end
			if (res_valid_q && res.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc.valid && acc.ready) begin
						kind_q <= acc.payload.kind;
						page_q <= acc.payload.address[OffsetBits +: PageW];
						n_q    <= n_eff;
						acc_cnt_q <= acc_cnt_q + ((acc.payload.kind == KIND_MODIFY) ?
							TotalW'(2) : TotalW'(1));
						state_q <= ST_REF;
					end
				end
				ST_REF: begin
					if ({1'b0, refresh_nx} >= interval_q || refresh_nx == '0) begin
						refresh_q <= '0;
						if (mode_q) ref_q <= '0;
					end else begin
						refresh_q <= refresh_nx;
					end
					idx_q   <= '0;
					state_q <= ST_HIT;
				end
				ST_HIT: begin
					if (rd_ok) begin
						if (valid_q[idx] && rd_page_q == page_q) begin
							ref_q[idx] <= 1'b1;
							if (writes) dirty_q[idx] <= 1'b1;
							res_q <= '{hit: 1'b1, evicted: 1'b0, victim_page: '0,
								write_back: 1'b0, frame_index: idx,
								access_total: acc_cnt_q, fault_total: fault_cnt_q,
								disk_write_total: wr_cnt_q};
							state_q <= ST_DONE;
						end else if (idx_q == CountW'(MaxFrames - 1)) begin
							fault_cnt_q <= fault_cnt_q + 1'b1;
							idx_q   <= '0;
							state_q <= ST_FREE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FREE: begin
					if (!valid_q[idx]) begin
						res_q <= '{hit: 1'b0, evicted: 1'b0, victim_page: '0,
							write_back: 1'b0, frame_index: idx,
							access_total: acc_cnt_q, fault_total: fault_cnt_q,
							disk_write_total: wr_cnt_q};
						state_q <= ST_DONE;
					end else if (idx_q + 1'b1 >= n_q) begin
						idx_q      <= mode_q ? '0 :
							(CountW'(hand_q) >= n_q ? '0 : CountW'(hand_q));
						step_q     <= '0;
						best_any_q <= 1'b0;
						state_q    <= ST_EVICT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EVICT: begin
					if (mode_q) begin
						if (rd_ok && step_q == CountW'(1)) begin
							res_q <= '{hit: 1'b0, evicted: 1'b1, victim_page: rd_page_q,
								write_back: dirty_q[idx], frame_index: idx,
								access_total: acc_cnt_q, fault_total: fault_cnt_q,
								disk_write_total: wr_cnt_q + TotalW'(dirty_q[idx])};
							if (dirty_q[idx]) wr_cnt_q <= wr_cnt_q + 1'b1;
							state_q <= ST_DONE;
						end else if (rd_ok) begin
							if (better) begin
								best_q     <= idx;
								best_cls_q <= cls;
								best_old_q <= old;
								best_any_q <= 1'b1;
							end
							if (idx_q + 1'b1 >= n_q) begin
								// final pick; its page is read on the next cycle
								idx_q   <= better ? idx_q : CountW'(best_q);
								step_q  <= CountW'(1);
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end else begin
						if (ref_q[idx]) begin
							ref_q[idx] <= 1'b0;
							idx_q <= (idx_q + 1'b1 >= n_q) ? '0 : idx_q + 1'b1;
						end else if (rd_ok) begin
							hand_q <= (idx_q + 1'b1 >= n_q) ? '0 : idx + 1'b1;
							res_q <= '{hit: 1'b0, evicted: 1'b1, victim_page: rd_page_q,
								write_back: dirty_q[idx], frame_index: idx,
								access_total: acc_cnt_q, fault_total: fault_cnt_q,
								disk_write_total: wr_cnt_q + TotalW'(dirty_q[idx])};
							if (dirty_q[idx]) wr_cnt_q <= wr_cnt_q + 1'b1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!res_q.hit) begin
						valid_q[res_q.frame_index] <= 1'b1;
						ref_q[res_q.frame_index]   <= 1'b1;
						dirty_q[res_q.frame_index] <= writes;
						stamp_q <= stamp_q + 1'b1;
					end
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !acc.ready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> res_valid_q)
		else $error("result not presented after completion");
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc.valid && acc.ready) |=> (state_q == ST_REF))
		else $error("accepted item did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.payload.hit) |-> !res.payload.evicted)
		else $error("hit reported with eviction");

endmodule

FILE: tb/page_replacement_clock_nru_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_replacement_clock_nru_tb
// Drives page accesses through the clock / NRU replacement engine under
// several policy, frame count and refresh settings, and checks every result
// against a behavioral page table kept in the testbench.
// ----------------------------------------------------------------------------
module page_replacement_clock_nru_tb;
	import pcn_pkg::*;

	localparam int LimitCycles = 4000000;

	typedef enum logic [KindW-1:0] {
		K_FETCH = 2'd0, K_LOAD = 2'd1, K_STORE = 2'd2, K_MODIFY = 2'd3
	} access_kind_t;

	typedef struct {
		access_kind_t kind;
		logic [31:0]  address;
		bit           has_fixed;
		result_t      fixed;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pcn_if #(.payload_t(access_t)) acc ();
	pcn_if #(.payload_t(result_t)) res ();
	pcn_if #(.payload_t(cfg_t))    cfg ();

	page_replacement_clock_nru dut (
		.clk(clk), .arst_n(arst_n), .acc(acc), .res(res), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// shadow page table
	logic [PageW-1:0]  pt_page [MaxFrames];
	bit                pt_valid [MaxFrames];
	bit                pt_ref [MaxFrames];
	bit                pt_dirty [MaxFrames];
	logic [StampW-1:0] pt_age [MaxFrames];
	logic [StampW-1:0] pt_stamp;
	logic [FrameW-1:0] pt_hand;
	logic [RefreshW-1:0] pt_refresh;
	logic [TotalW-1:0] pt_accesses, pt_faults, pt_writes;
	bit                pt_mode;
	logic [CountW-1:0] pt_frames;
	logic [IntervalW-1:0] pt_interval;

	result_t expected_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int evictions_seen = 0;
	int cycle_count = 0;
	int idle_pct = 15;
	bit hold_off = 0;

	function automatic int frames_active();
		if (pt_frames == 0) return 1;
		if (pt_frames > MaxFrames) return MaxFrames;
		return pt_frames;
	endfunction

	function automatic result_t predict_access(access_kind_t kind, logic [31:0] address);
		result_t r;
		logic [PageW-1:0] page;
		int n, f, h, step, best, best_cls, cls;
		logic [StampW-1:0] best_old, old;
		bit found, writes;
		page = address[OffsetBits +: PageW];
		n = frames_active();
		writes = kind >= K_STORE;
		r = '0;
		pt_accesses += (kind == K_MODIFY) ? TotalW'(2) : TotalW'(1);
		pt_refresh = pt_refresh + 1'b1;
		if (pt_refresh >= pt_interval || pt_refresh == 0) begin
			pt_refresh = '0;
			if (pt_mode)
				for (int i = 0; i < MaxFrames; i++) pt_ref[i] = 0;
		end
		f = 0;
		found = 0;
		for (int i = 0; i < MaxFrames; i++)
			if (!found && pt_valid[i] && pt_page[i] == page) begin
				found = 1;
				f = i;
			end
		if (found) begin
			r.hit = 1'b1;
			pt_ref[f] = 1;
			if (writes) pt_dirty[f] = 1;
		end else begin
			pt_faults++;
			for (int i = 0; i < n; i++)
				if (!found && !pt_valid[i]) begin
					found = 1;
					f = i;
				end
			if (!found) begin
				if (pt_mode) begin
					best = 0;
					best_cls = 4;
					best_old = 0;
					for (int i = 0; i < n; i++) begin
						cls = pt_ref[i] * 2 + pt_dirty[i];
						old = pt_stamp - pt_age[i];
						if (cls < best_cls || (cls == best_cls && old > best_old)) begin
							best = i;
							best_cls = cls;
							best_old = old;
						end
					end
					f = best;
				end else begin
					h = pt_hand;
					if (h >= n) h = 0;
					for (step = 0; step < 2 * n + 1; step++) begin
						if (!pt_ref[h]) break;
						pt_ref[h] = 0;
						h = (h + 1 >= n) ? 0 : h + 1;
					end
					pt_hand = FrameW'((h + 1 >= n) ? 0 : h + 1);
					f = h;
				end
				r.evicted = 1'b1;
				r.victim_page = pt_page[f];
				r.write_back = pt_dirty[f];
				if (pt_dirty[f]) pt_writes++;
			end
			pt_page[f] = page;
			pt_valid[f] = 1;
			pt_ref[f] = 1;
			pt_dirty[f] = writes;
			pt_age[f] = pt_stamp;
			pt_stamp++;
		end
		r.frame_index = FrameW'(f);
		r.access_total = pt_accesses;
		r.fault_total = pt_faults;
		r.disk_write_total = pt_writes;
		return r;
	endfunction

	initial begin
		for (int i = 0; i < MaxFrames; i++) begin
			pt_valid[i] = 0; pt_ref[i] = 0; pt_dirty[i] = 0;
		end
		pt_stamp = 0; pt_hand = 0; pt_refresh = 0;
		pt_accesses = 0; pt_faults = 0; pt_writes = 0;
		pt_mode = 0; pt_frames = 64; pt_interval = 1000;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LimitCycles) begin
			$display("page_replacement_clock_nru regression: fail");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (res.payload.evicted) evictions_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", res.payload);
			end else begin
				exp_r = expected_results.pop_front();
				if (res.payload !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp_r, res.payload);
				end
			end
		end
	end

	task automatic send_access(access_kind_t kind, logic [31:0] address, bit has_fixed,
			result_t fixed);
		result_t p;
		acc.valid <= 1'b1;
		acc.payload <= '{kind: kind, address: address};
		do @(posedge clk); while (!acc.ready);
		p = predict_access(kind, address);
		if (has_fixed && p !== fixed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees: table %p, predicted %p", fixed, p);
		end
		expected_results.push_back(p);
		if ($urandom_range(99) < idle_pct) begin
			acc.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		acc.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] index, logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.payload <= '{index: index, data: data};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (index)
			REG_MODE: pt_mode = data[0];
			REG_FRAMES: pt_frames = data[CountW-1:0];
			REG_INTERVAL: pt_interval = data[IntervalW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// page pool of up to 2*(span+1) pages plus one random address in ten, so hits and evictions both occur
	function automatic logic [31:0] pool_addr(int span);
		logic [31:0] a;
		a = $urandom();
		if ($urandom_range(9) == 0) return a;
		a[31:OffsetBits] = ($urandom_range(3) == 0) ? ~PageW'($urandom_range(span))
			: PageW'($urandom_range(span));
		return a;
	endfunction

	task automatic random_phase(int count, int span);
		for (int i = 0; i < count; i++)
			send_access(access_kind_t'($urandom_range(3)), pool_addr(span), 0, '0);
	endtask

	stim_row_t table_rows[$];

	function automatic result_t fixed_result(bit hit, logic [5:0] fr, int acc_t, int flt);
		result_t r;
		r = '0;
		r.hit = hit; r.frame_index = fr;
		r.access_total = acc_t; r.fault_total = flt;
		return r;
	endfunction

	initial begin
		acc.valid = 1'b0; acc.payload = '0;
		cfg.valid = 1'b0; cfg.payload = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: first accesses fill frames from zero
		table_rows.push_back('{K_FETCH, 32'h0000_0000, 1, fixed_result(0, 0, 1, 1)});
		table_rows.push_back('{K_MODIFY, 32'hFFFF_FFFF, 1, fixed_result(0, 1, 3, 2)});
		table_rows.push_back('{K_LOAD, 32'h0000_07FF, 1, fixed_result(1, 0, 4, 2)});
		table_rows.push_back('{K_STORE, 32'hFFFF_F800, 1, fixed_result(1, 1, 5, 2)});
		table_rows.push_back('{K_STORE, 32'h0000_0800, 1, fixed_result(0, 2, 6, 3)});
		table_rows.push_back('{K_FETCH, 32'hAAAA_AAAA, 0, '0});
		table_rows.push_back('{K_LOAD, 32'h5555_5555, 0, '0});
		foreach (table_rows[i])
			send_access(table_rows[i].kind, table_rows[i].address,
				table_rows[i].has_fixed, table_rows[i].fixed);
		drain();

		// clock with two frames: sweep and wrap
		write_reg(REG_FRAMES, 32'd2);
		for (int i = 0; i < 8; i++)
			send_access(access_kind_t'(i % 4), 32'(i) << OffsetBits, 0, '0);
		drain();
		// NRU, single frame, refresh every access (zero behaves as one)
		write_reg(REG_MODE, 32'd1);
		write_reg(REG_FRAMES, 32'd0);
		write_reg(REG_INTERVAL, 32'd0);
		for (int i = 0; i < 6; i++)
			send_access(access_kind_t'(i % 4), 32'(i % 3) << OffsetBits, 0, '0);
		drain();
		// frame count above range clamps to the maximum
		write_reg(REG_FRAMES, 32'd127);
		write_reg(REG_INTERVAL, 32'h1F_FFFF);
		random_phase(200, 90);
		drain();

		// random phases across settings; the last one has no idling
		write_reg(REG_MODE, 32'd0);
		write_reg(REG_FRAMES, 32'd4);
		random_phase(250, 12);
		drain();
		write_reg(REG_MODE, 32'd1);
		write_reg(REG_FRAMES, 32'd8);
		write_reg(REG_INTERVAL, 32'd5);
		random_phase(250, 20);
		drain();
		// pressure: receiver holds off while further accesses are stalled
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			random_phase(20, 12);
		join
		drain();
		write_reg(REG_MODE, 32'd0);
		write_reg(REG_FRAMES, 32'd64);
		write_reg(REG_INTERVAL, 32'd1);
		random_phase(200, 100);
		drain();
		// lowered count: upper frames stay resident and can still hit
		write_reg(REG_FRAMES, 32'd3);
		write_reg(REG_MODE, 32'd1);
		write_reg(REG_INTERVAL, 32'd1048576);
		random_phase(150, 100);
		drain();
		idle_pct = 0;
		write_reg(REG_FRAMES, 32'd1);
		write_reg(REG_MODE, 32'd0);
		random_phase(200, 6);
		drain();

		$display("covered %0d results, %0d evictions, clock and NRU policies",
			results_seen, evictions_seen);
		$display("frame counts 0..127 and refresh intervals 0..2^21-1 exercised");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("page_replacement_clock_nru regression: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("page_replacement_clock_nru regression: fail");
		end
		$finish;
	end
endmodule
